### sv/bums_pkg.sv
// ============================================================================
// bums_pkg - shared types for the bottom-up merge sorter
// Controller states and the command and status groups that join the
// controller to the datapath.
// ============================================================================
`default_nettype none

package bums_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_READ,
        S_MERGE,
        S_NEXT,
        S_DRAIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // store the accepted key (dropped when full)
        logic pass_init; // width 1, first run, sort from buffer A
        logic run_init;  // set up bounds and pointers of the next run pair
        logic rd;        // read both run heads
        logic mrg_wr;    // write the smaller head, advance its pointer
        logic pass_next; // double the width, swap buffers
        logic drain_rd;  // read the next sorted key into the output register
        logic clr_cnt;   // empty the set
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cnt_gt1;    // more than one key held
        logic run_last;   // this merge write ends the run pair
        logic pass_last;  // the current run pair ends the pass
        logic w2_lt_n;    // doubled width still below the key count
        logic drain_last; // next drain read is the final key
        logic out_vld;    // output register holds an item
        logic out_busy;   // output register holds an item that is not taken
    } t_sts;

endpackage

`default_nettype wire

### sv/bums_dp.sv
// ============================================================================
// bums_dp - merge sorter datapath
// Two key buffers, run bounds and pointers, the compare-and-select merge
// step and the output register.
// ============================================================================
`default_nettype none

module bums_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bums_pkg::t_cmd             i_cmd,
    output bums_pkg::t_sts                  o_sts,
    input  wire logic [bums_pkg::KEY_W-1:0] i_key,
    input  wire logic                       i_m_tready,
    output logic                            o_m_tvalid,
    output logic [bums_pkg::KEY_W-1:0]      o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [bums_pkg::KEY_W-1:0] mem_a [DEPTH];
    logic [bums_pkg::KEY_W-1:0] mem_b [DEPTH];

    logic [bums_pkg::KEY_W-1:0] r_a_l, r_a_r, r_b_l, r_b_r;
    logic [CW-1:0]              r_cnt, r_lo, r_mid, r_hi, r_left, r_right, r_k, r_d;
    logic [CW:0]                r_w;
    logic                       r_par;
    logic                       r_out_vld, r_out_last;

    logic [SW-1:0]              n_ext, lo_w, lo_2w, mid_v, hi_v;
    logic [bums_pkg::KEY_W-1:0] rl, rr, mrg_d;
    logic                       take_left, not_full, rd_en;
    logic                       we_a, we_b;
    logic [AW-1:0]              wa_a, ra_l, ra_r;
    logic [bums_pkg::KEY_W-1:0] wd_a;

    assign n_ext = SW'(r_cnt);
    assign lo_w  = SW'(r_lo) + SW'(r_w);
    assign lo_2w = SW'(r_lo) + (SW'(r_w) << 1);
    assign mid_v = (lo_w < n_ext) ? lo_w : n_ext;
    assign hi_v  = (lo_2w < n_ext) ? lo_2w : n_ext;

    assign rl = r_par ? r_b_l : r_a_l;
    assign rr = r_par ? r_b_r : r_a_r;

    // stable: the left run wins ties
    assign take_left = (r_right >= r_hi) ||
                       ((r_left < r_mid) && ($signed(rl) <= $signed(rr)));
    assign mrg_d     = take_left ? rl : rr;

    assign not_full = r_cnt < CW'(DEPTH);
    assign we_a     = (i_cmd.load_wr && not_full) || (i_cmd.mrg_wr && r_par);
    assign wa_a     = i_cmd.load_wr ? r_cnt[AW-1:0] : r_k[AW-1:0];
    assign wd_a     = i_cmd.load_wr ? i_key : mrg_d;
    assign we_b     = i_cmd.mrg_wr && !r_par;

    assign rd_en = i_cmd.rd || i_cmd.drain_rd;
    assign ra_l  = i_cmd.drain_rd ? r_d[AW-1:0] : r_left[AW-1:0];
    assign ra_r  = r_right[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_a] <= wd_a;
        end
        if (rd_en) begin
            r_a_l <= mem_a[ra_l];
            r_a_r <= mem_a[ra_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[r_k[AW-1:0]] <= mrg_d;
        end
        if (rd_en) begin
            r_b_l <= mem_b[ra_l];
            r_b_r <= mem_b[ra_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load_wr && not_full) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.clr_cnt) begin
                r_cnt <= '0;
            end
            if (i_cmd.drain_rd) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_init) begin
            r_w   <= (CW+1)'(1);
            r_lo  <= '0;
            r_par <= 1'b0;
            r_d   <= '0;
        end
        if (i_cmd.run_init) begin
            r_mid   <= mid_v[CW-1:0];
            r_hi    <= hi_v[CW-1:0];
            r_left  <= r_lo;
            r_right <= mid_v[CW-1:0];
            r_k     <= r_lo;
        end
        if (i_cmd.mrg_wr) begin
            r_k <= r_k + CW'(1);
            if (take_left) begin
                r_left <= r_left + CW'(1);
            end else begin
                r_right <= r_right + CW'(1);
            end
            if (o_sts.run_last) begin
                r_lo <= r_hi;
            end
        end
        if (i_cmd.pass_next) begin
            r_w   <= r_w << 1;
            r_lo  <= '0;
            r_par <= ~r_par;
        end
        if (i_cmd.drain_rd) begin
            r_d        <= r_d + CW'(1);
            r_out_last <= o_sts.drain_last;
        end
    end

    assign o_sts.cnt_gt1    = r_cnt > CW'(1);
    assign o_sts.run_last   = (r_k + CW'(1)) == r_hi;
    assign o_sts.pass_last  = r_hi == r_cnt;
    assign o_sts.w2_lt_n    = (SW'(r_w) << 1) < n_ext;
    assign o_sts.drain_last = (r_d + CW'(1)) == r_cnt;
    assign o_sts.out_vld    = r_out_vld;
    assign o_sts.out_busy   = r_out_vld && !i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = rl;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

### sv/bums_ctrl.sv
// ============================================================================
// bums_ctrl - merge sorter controller
// Sequences load, the merge passes and the drain of the sorted set.
// ============================================================================
`default_nettype none

module bums_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_s_tlast,
    output logic                 o_s_tready,
    input  wire bums_pkg::t_sts  i_sts,
    output bums_pkg::t_cmd       o_cmd
);

    bums_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bums_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bums_pkg::S_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = bums_pkg::S_PASS;
                end
            end
            bums_pkg::S_PASS: begin
                if (!i_sts.out_vld) begin
                    n_state = i_sts.cnt_gt1 ? bums_pkg::S_RUN : bums_pkg::S_DRAIN;
                end
            end
            bums_pkg::S_RUN: begin
                n_state = bums_pkg::S_READ;
            end
            bums_pkg::S_READ: begin
                n_state = bums_pkg::S_MERGE;
            end
            bums_pkg::S_MERGE: begin
                if (!i_sts.run_last) begin
                    n_state = bums_pkg::S_READ;
                end else if (!i_sts.pass_last) begin
                    n_state = bums_pkg::S_RUN;
                end else begin
                    n_state = bums_pkg::S_NEXT;
                end
            end
            bums_pkg::S_NEXT: begin
                n_state = i_sts.w2_lt_n ? bums_pkg::S_RUN : bums_pkg::S_DRAIN;
            end
            bums_pkg::S_DRAIN: begin
                if (!i_sts.out_busy && i_sts.drain_last) begin
                    n_state = bums_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = bums_pkg::S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            bums_pkg::S_LOAD: begin
                o_s_tready    = 1'b1;
                o_cmd.load_wr = i_s_tvalid;
            end
            bums_pkg::S_PASS: begin
                o_cmd.pass_init = !i_sts.out_vld;
            end
            bums_pkg::S_RUN: begin
                o_cmd.run_init = 1'b1;
            end
            bums_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
            end
            bums_pkg::S_MERGE: begin
                o_cmd.mrg_wr = 1'b1;
            end
            bums_pkg::S_NEXT: begin
                o_cmd.pass_next = 1'b1;
            end
            bums_pkg::S_DRAIN: begin
                o_cmd.drain_rd = !i_sts.out_busy;
                o_cmd.clr_cnt  = !i_sts.out_busy && i_sts.drain_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/bottom_up_merge_sorter.sv
// ============================================================================
// bottom_up_merge_sorter - stable ascending sort of a set of signed keys
// Collects keys until a last-marked item, merge sorts them and streams them out.
// ============================================================================
// Keys arrive one per item on the slave side; tlast closes the set. Up to
// DEPTH keys are held, later keys of the same set are dropped but the set is
// still sorted when its tlast item arrives. The set is sorted ascending as
// signed two's complement values, equal keys keeping arrival order, and sent
// on the master side with tlast on its final key. The slave side stays ready
// through loading. For a set of n keys, each of the ceil(log2 n) merge passes
// does, per key, a registered read of both run heads, then a compare and
// write of the smaller one, plus a setup step per run pair and one per pass;
// the drain sends one key per cycle while the master side takes them. The
// sort time is set by the read-then-write merge loop on the buffer memories.
// Loading of the next set starts while the final sorted key still waits on
// the master side; its sort begins once that key has been taken.
// ============================================================================
`default_nettype none

module bottom_up_merge_sorter #(
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [bums_pkg::KEY_W-1:0] i_s_tdata,  // [31:0] key_in
    input  wire logic                       i_s_tlast,  // is_final
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [bums_pkg::KEY_W-1:0]      o_m_tdata,  // [31:0] key_out
    output logic                            o_m_tlast   // run_end
);

    bums_pkg::t_cmd cmd;
    bums_pkg::t_sts sts;

    // sequence load, merge passes and drain
    bums_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // ping-pong buffers, merge step and output register
    bums_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_key      (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

### sv/bums_chk.sv
// ============================================================================
// bums_chk - port checker for the merge sorter
// Watches the stream ports of the top level over time.
// ============================================================================
`default_nettype none

module bums_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // hold a stalled output item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    // closing item of a set stops loading
    a_close_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input still taken after the closing item");

    // reset empties the output register
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind bottom_up_merge_sorter bums_chk u_bums_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
